>>> src/kism_pkg.sv
// shared types and constants for the keyed interval set merge block
package kism_pkg;

	localparam int unsigned KEY_SLOTS_DEF = 16;
	localparam int unsigned INTERVALS_DEF = 16;
	localparam int unsigned ID_W = 63;
	localparam int unsigned KEY_W = 64;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// one interval, first and last id inclusive
	typedef struct packed {
		logic [ID_W-1:0] first;
		logic [ID_W-1:0] last;
	} ival_t;

endpackage

>>> src/kism_ival_mem.sv
// interval memory: one write port, one registered read port
module kism_ival_mem #(
	parameter int unsigned DEPTH = kism_pkg::KEY_SLOTS_DEF * kism_pkg::INTERVALS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  kism_pkg::ival_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output kism_pkg::ival_t          rdata
);

	kism_pkg::ival_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/keyed_interval_set_merge_top.sv
// keyed interval set merge: key table, interval walk and repack
//
// usage: drive req_type, key_hi, key_lo, range_start and range_end and pulse
// start while busy is low; the beat is taken at that edge and busy rises.
// one result beat follows, marked by done for one cycle, with modified,
// present and full_res; busy falls in the same cycle done is high.
// an add or a query first scans the key table, one slot a cycle; an add
// on a stored key then reads the key's n stored intervals from the interval
// memory, one a cycle through the registered read port, and merges them on
// the fly into a scratch buffer; unless the range was already covered or the
// key is full, it then copies m <= n+1 intervals back into the memory, one a
// cycle. a query reads the intervals only.
// interval memory entries carry no reset; the key valid bits and interval
// counts sit in flip-flops cleared by reset and by a clear request.
// the receiver cannot stall: the result beat is shown for one cycle only.
module keyed_interval_set_merge_top #(
	parameter int unsigned KEY_SLOTS = kism_pkg::KEY_SLOTS_DEF,
	parameter int unsigned INTERVALS_PER_KEY = kism_pkg::INTERVALS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 req_type,
	input  logic [kism_pkg::KEY_W-1:0] key_hi,
	input  logic [kism_pkg::KEY_W-1:0] key_lo,
	input  logic [kism_pkg::ID_W-1:0]  range_start,
	input  logic [kism_pkg::ID_W-1:0]  range_end,
	output logic                       done,
	output logic                       modified,
	output logic                       present,
	output logic                       full_res
);

	localparam int unsigned KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int unsigned CW = $clog2(INTERVALS_PER_KEY + 2);
	localparam int unsigned DEPTH = KEY_SLOTS * INTERVALS_PER_KEY;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned KCW = $clog2(KEY_SLOTS + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_WALK  = 7'b0000100,
		ST_TAIL  = 7'b0001000,
		ST_WBACK = 7'b0010000,
		ST_DONE  = 7'b0100000,
		ST_NEW   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [1:0]                 req_q;
	logic [kism_pkg::KEY_W-1:0] hi_q, lo_q;
	logic [kism_pkg::ID_W-1:0]  s_q, e_q;

	logic [KEY_SLOTS-1:0]       kvalid_q;
	logic [kism_pkg::KEY_W-1:0] khi_q [KEY_SLOTS];
	logic [kism_pkg::KEY_W-1:0] klo_q [KEY_SLOTS];
	logic [CW-1:0]              kcnt_q [KEY_SLOTS];

	logic [KCW-1:0] scan_q;
	logic           hit_q, free_found_q;
	logic [KW-1:0]  hit_idx_q, free_idx_q;

	logic [CW-1:0]  n_q;
	logic [CW-1:0]  rd_q;
	logic           rvalid_s1;
	logic [CW-1:0]  m_q;
	logic           placed_q, inside_q, pres_q;

	kism_pkg::ival_t tmp_q [INTERVALS_PER_KEY + 1];
	logic [CW-1:0]   wb_q;

	logic mod_q, full_q;

	// memory port signals
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	kism_pkg::ival_t mem_wdata, mem_rdata;

	kism_ival_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	function automatic logic [AW-1:0] addr_of(logic [KW-1:0] k, logic [CW-1:0] i);
		logic [AW+CW-1:0] a;
		a = (AW+CW)'(k) * (AW+CW)'(INTERVALS_PER_KEY) + (AW+CW)'(i);
		return a[AW-1:0];
	endfunction

	assign busy = (state_q != ST_IDLE);

	logic [KW-1:0] scan_idx;
	assign scan_idx = scan_q[KW-1:0];

	assign mem_raddr = addr_of(hit_idx_q, rd_q);
	assign mem_we    = (state_q == ST_WBACK) && (wb_q < m_q);
	assign mem_waddr = addr_of(hit_idx_q, wb_q);
	assign mem_wdata = tmp_q[wb_q];

	// merge step on one stored interval
	logic [kism_pkg::ID_W:0] a_w, b_w, s_w, e_w;
	logic below, above;
	assign a_w = {1'b0, mem_rdata.first};
	assign b_w = {1'b0, mem_rdata.last};
	assign s_w = {1'b0, s_q};
	assign e_w = {1'b0, e_q};
	assign below = (b_w + 1'b1) < s_w;
	assign above = a_w > (e_w + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kvalid_q     <= '0;
			done         <= 1'b0;
			modified     <= 1'b0;
			present      <= 1'b0;
			full_res     <= 1'b0;
			rvalid_s1    <= 1'b0;
			for (int k = 0; k < KEY_SLOTS; k++) begin
				kcnt_q[k] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req_type;
						hi_q  <= key_hi;
						lo_q  <= key_lo;
						if (req_type == kism_pkg::REQ_ADD && range_start > range_end) begin
							s_q <= range_end;
							e_q <= range_start;
						end else begin
							s_q <= range_start;
							e_q <= range_end;
						end
						scan_q       <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						mod_q        <= 1'b0;
						full_q       <= 1'b0;
						pres_q       <= 1'b0;
						if (req_type == kism_pkg::REQ_CLEAR) begin
							kvalid_q <= '0;
							for (int k = 0; k < KEY_SLOTS; k++) begin
								kcnt_q[k] <= '0;
							end
							state_q <= ST_DONE;
						end else if (req_type == kism_pkg::REQ_ADD ||
						             req_type == kism_pkg::REQ_QUERY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (kvalid_q[scan_idx] && khi_q[scan_idx] == hi_q &&
					    klo_q[scan_idx] == lo_q && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= scan_idx;
					end
					if (!kvalid_q[scan_idx] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= scan_idx;
					end
					if (scan_q == KCW'(KEY_SLOTS - 1)) begin
						state_q <= ST_NEW;
					end
					scan_q <= scan_q + 1'b1;
				end
				ST_NEW: begin
					// decide path after the scan
					rd_q      <= '0;
					rvalid_s1 <= 1'b0;
					m_q       <= '0;
					placed_q  <= 1'b0;
					inside_q  <= 1'b0;
					n_q       <= kcnt_q[hit_idx_q];
					if (hit_q) begin
						state_q <= ST_WALK;
					end else if (req_q == kism_pkg::REQ_QUERY) begin
						state_q <= ST_DONE;
					end else if (free_found_q) begin
						kvalid_q[free_idx_q] <= 1'b1;
						khi_q[free_idx_q]    <= hi_q;
						klo_q[free_idx_q]    <= lo_q;
						kcnt_q[free_idx_q]   <= CW'(1);
						hit_idx_q <= free_idx_q;
						tmp_q[0]  <= '{first: s_q, last: e_q};
						m_q       <= CW'(1);
						wb_q      <= '0;
						mod_q     <= 1'b1;
						state_q   <= ST_WBACK;
					end else begin
						full_q  <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_WALK: begin
					if (rd_q < n_q) begin
						rd_q <= rd_q + 1'b1;
					end
					rvalid_s1 <= (rd_q < n_q);
					if (rvalid_s1) begin
						if (req_q == kism_pkg::REQ_QUERY) begin
							if (s_q >= mem_rdata.first && s_q <= mem_rdata.last) begin
								pres_q <= 1'b1;
							end
						end else begin
							if (s_q >= mem_rdata.first && e_q <= mem_rdata.last) begin
								inside_q <= 1'b1;
							end
							if (below) begin
								tmp_q[m_q] <= mem_rdata;
								m_q <= m_q + 1'b1;
							end else if (above) begin
								if (!placed_q) begin
									tmp_q[m_q]        <= '{first: s_q, last: e_q};
									tmp_q[m_q + 1'b1] <= mem_rdata;
									m_q      <= m_q + 2'd2;
									placed_q <= 1'b1;
								end else begin
									tmp_q[m_q] <= mem_rdata;
									m_q <= m_q + 1'b1;
								end
							end else begin
								if (mem_rdata.first < s_q) s_q <= mem_rdata.first;
								if (mem_rdata.last > e_q) e_q <= mem_rdata.last;
							end
						end
					end
					if (!rvalid_s1 && rd_q >= n_q && rd_q != '0 || n_q == '0) begin
						state_q <= ST_TAIL;
					end else if (rvalid_s1 && rd_q >= n_q) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					rvalid_s1 <= 1'b0;
					wb_q <= '0;
					if (req_q == kism_pkg::REQ_QUERY || inside_q) begin
						state_q <= ST_DONE;
					end else begin
						if (!placed_q) begin
							tmp_q[m_q] <= '{first: s_q, last: e_q};
						end
						if ((placed_q ? m_q : m_q + 1'b1) > CW'(INTERVALS_PER_KEY)) begin
							full_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							if (!placed_q) m_q <= m_q + 1'b1;
							kcnt_q[hit_idx_q] <= placed_q ? m_q : m_q + 1'b1;
							mod_q   <= 1'b1;
							state_q <= ST_WBACK;
						end
					end
				end
				ST_WBACK: begin
					wb_q <= wb_q + 1'b1;
					if (wb_q + 1'b1 >= m_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					done     <= 1'b1;
					modified <= mod_q;
					present  <= pres_q;
					full_res <= full_q;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// never report a change and full together
	a_mod_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(modified && full_res))
		else $error("modified and full_res both set");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("memory write while idle");

endmodule
